### rtl/mafi_pkg.sv
package mafi_pkg;

  localparam int OffsetBits = 32;
  localparam int CountBits  = 24;

  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_FRAME = 3'd1;
  localparam logic [2:0] KIND_ID3V1 = 3'd2;
  localparam logic [2:0] KIND_ID3V2 = 3'd3;
  localparam logic [2:0] KIND_LYR   = 3'd4;
  localparam logic [2:0] KIND_XING  = 3'd5;
  localparam logic [2:0] KIND_VBRI  = 3'd6;
  localparam logic [2:0] KIND_APE   = 3'd7;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_END  = 2'd1;
  localparam logic [1:0] ST_STOP = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  localparam logic [1:0] ADDR_FILE_LENGTH = 2'd0;
  localparam logic [1:0] ADDR_MIN_TAIL    = 2'd1;

  // Classification codes from the front end.
  typedef enum logic [2:0] {
    CL_OTHER, CL_SYNC, CL_ID3V1, CL_ID3V2, CL_LYR, CL_XING, CL_VBRI, CL_APE
  } class_t;

  typedef struct packed {
    class_t      cls;
    logic [31:0] w0;
    logic [27:0] id3_size;
    logic [31:0] w3;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_MUL, S_DIV, S_FINISH, S_TMUL, S_TDIV, S_OUT
  } state_t;

  function automatic logic [8:0] bitrate(input logic [1:0] ver, input logic [1:0] lay,
                                         input logic [3:0] idx);
    logic [8:0] r;
    r = 9'd0;
    if (ver == 2'd1) begin
      unique case (lay)
        2'd1: case (idx)
          4'd1: r = 9'd32;  4'd2: r = 9'd64;  4'd3: r = 9'd96;  4'd4: r = 9'd128;
          4'd5: r = 9'd160; 4'd6: r = 9'd192; 4'd7: r = 9'd224; 4'd8: r = 9'd256;
          4'd9: r = 9'd288; 4'd10: r = 9'd320; 4'd11: r = 9'd352; 4'd12: r = 9'd384;
          4'd13: r = 9'd416; 4'd14: r = 9'd448; default: r = 9'd0;
        endcase
        2'd2: case (idx)
          4'd1: r = 9'd32;  4'd2: r = 9'd48;  4'd3: r = 9'd56;  4'd4: r = 9'd64;
          4'd5: r = 9'd80;  4'd6: r = 9'd96;  4'd7: r = 9'd112; 4'd8: r = 9'd128;
          4'd9: r = 9'd160; 4'd10: r = 9'd192; 4'd11: r = 9'd224; 4'd12: r = 9'd256;
          4'd13: r = 9'd320; 4'd14: r = 9'd384; default: r = 9'd0;
        endcase
        default: case (idx)
          4'd1: r = 9'd32;  4'd2: r = 9'd40;  4'd3: r = 9'd48;  4'd4: r = 9'd56;
          4'd5: r = 9'd64;  4'd6: r = 9'd80;  4'd7: r = 9'd96;  4'd8: r = 9'd112;
          4'd9: r = 9'd128; 4'd10: r = 9'd160; 4'd11: r = 9'd192; 4'd12: r = 9'd224;
          4'd13: r = 9'd256; 4'd14: r = 9'd320; default: r = 9'd0;
        endcase
      endcase
    end else if (lay == 2'd1) begin
      case (idx)
        4'd1: r = 9'd32;  4'd2: r = 9'd48;  4'd3: r = 9'd56;  4'd4: r = 9'd64;
        4'd5: r = 9'd80;  4'd6: r = 9'd96;  4'd7: r = 9'd112; 4'd8: r = 9'd128;
        4'd9: r = 9'd144; 4'd10: r = 9'd160; 4'd11: r = 9'd176; 4'd12: r = 9'd192;
        4'd13: r = 9'd224; 4'd14: r = 9'd256; default: r = 9'd0;
      endcase
    end else begin
      case (idx)
        4'd1: r = 9'd8;   4'd2: r = 9'd16;  4'd3: r = 9'd24;  4'd4: r = 9'd32;
        4'd5: r = 9'd40;  4'd6: r = 9'd48;  4'd7: r = 9'd56;  4'd8: r = 9'd64;
        4'd9: r = 9'd80;  4'd10: r = 9'd96; 4'd11: r = 9'd112; 4'd12: r = 9'd128;
        4'd13: r = 9'd144; 4'd14: r = 9'd160; default: r = 9'd0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [15:0] sample_rate(input logic [1:0] ver, input logic [1:0] idx);
    logic [15:0] r;
    r = 16'd0;
    unique case (ver)
      2'd2: case (idx)
        2'd0: r = 16'd22050; 2'd1: r = 16'd24000; 2'd2: r = 16'd16000; default: r = 16'd0;
      endcase
      2'd3: case (idx)
        2'd0: r = 16'd11025; 2'd1: r = 16'd12000; 2'd2: r = 16'd8000; default: r = 16'd0;
      endcase
      default: case (idx)
        2'd0: r = 16'd44100; 2'd1: r = 16'd48000; 2'd2: r = 16'd32000; default: r = 16'd0;
      endcase
    endcase
    return r;
  endfunction

  function automatic logic [10:0] samples_per_frame(input logic [1:0] ver,
                                                    input logic [1:0] lay);
    logic [10:0] r;
    if (lay == 2'd1) r = 11'd384;
    else if (lay == 2'd2 || ver == 2'd1) r = 11'd1152;
    else r = 11'd576;
    return r;
  endfunction

endpackage

### rtl/mafi_front.sv
// Accepts input items, classifies the first word and pushes a compact entry
// into a two-deep queue toward the back end.
module mafi_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [127:0]         in_data,
  output logic                 q_valid,
  input  logic                 q_pop,
  output mafi_pkg::entry_t     q_head
);

  logic [31:0] w0, w1, w2, w3;
  mafi_pkg::entry_t ent;
  mafi_pkg::entry_t slot [2];
  logic [1:0] cnt;
  logic       rd_ptr, wr_ptr;
  logic       push;

  assign w0 = in_data[31:0];
  assign w1 = in_data[63:32];
  assign w2 = in_data[95:64];
  assign w3 = in_data[127:96];

  // Classify the leading word.
  always_comb begin
    ent.w0 = w0;
    ent.w3 = w3;
    ent.id3_size = {w1[14:8], w1[6:0], w2[30:24], w2[22:16]};
    if ((w0 & 32'hFFE00000) == 32'hFFE00000)      ent.cls = mafi_pkg::CL_SYNC;
    else if (w0[31:8] == 24'h544147)              ent.cls = mafi_pkg::CL_ID3V1;
    else if (w0[31:8] == 24'h494433)              ent.cls = mafi_pkg::CL_ID3V2;
    else if (w0 == 32'h4C595249)                  ent.cls = mafi_pkg::CL_LYR;
    else if (w0 == 32'h58696E67)                  ent.cls = mafi_pkg::CL_XING;
    else if (w0 == 32'h56425249)                  ent.cls = mafi_pkg::CL_VBRI;
    else if (w0 == 32'h41504554)                  ent.cls = mafi_pkg::CL_APE;
    else                                          ent.cls = mafi_pkg::CL_OTHER;
  end

  assign in_ready = (cnt != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt != 2'd0);
  assign q_head   = slot[rd_ptr];

  // Queue storage and pointers.
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= ent;
    if (rst) begin
      cnt <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

### rtl/mafi_divider.sv
// Radix-2 restoring divider: 64-bit dividend by 16-bit divisor, one quotient
// bit per cycle.
module mafi_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);

  logic [63:0] q;
  logic [16:0] rem;
  logic [6:0]  cnt;
  logic [16:0] trial;
  logic [17:0] diff;

  assign trial = {rem[15:0], q[63]};
  assign diff  = {1'b0, trial} - {2'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= 7'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 7'd0;
    end else if (busy) begin
      cnt <= cnt + 7'd1;
      if (cnt == 7'd63) busy <= 1'b0;
    end
  end

  // Shift one dividend bit into the remainder per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      rem <= 17'd0;
    end else if (busy) begin
      if (!diff[17]) begin
        rem <= diff[16:0];
        q <= {q[62:0], 1'b1};
      end else begin
        rem <= trial;
        q <= {q[62:0], 1'b0};
      end
    end
  end

  assign quotient = q;

endmodule

### rtl/mafi_back.sv
// Executes one queued entry: header decode, size and time computation
// through a shared serial divider, state update and result register.
module mafi_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  mafi_pkg::entry_t      q_head,
  input  logic [31:0]           file_length,
  input  logic [9:0]            min_tail_bytes,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            record_kind,
  output logic [31:0]           record_offset,
  output logic [31:0]           record_size,
  output logic [47:0]           record_time,
  output logic [31:0]           next_offset,
  output logic [1:0]            scan_status,
  output logic [23:0]           frames_seen,
  output logic [31:0]           bytes_total,
  output logic [15:0]           largest_frame,
  output logic                  variable_rate,
  output logic [31:0]           bitrate_sum
);

  mafi_pkg::state_t state, state_next;
  mafi_pkg::entry_t cur;

  logic [mafi_pkg::OffsetBits-1:0] cur_offset;
  logic        first_done;
  logic [1:0]  stopped;
  logic [1:0]  mpeg_ver, layer_num;
  logic [15:0] rate_hz;
  logic [10:0] samples_frame;
  logic [8:0]  first_bitrate;
  logic [mafi_pkg::CountBits-1:0] frame_cnt;
  logic [31:0] size_sum;
  logic [15:0] size_max;
  logic        vbr_flag;
  logic [31:0] rate_sum;

  logic [8:0]  br;
  logic [34:0] tsamp;
  logic        div_start, div_busy;
  logic [63:0] div_a, div_q;
  logic        out_full;

  logic [1:0]  vid_ver, lid_lay;
  logic [1:0]  eff_ver, eff_lay;
  logic [8:0]  br_calc;
  logic [15:0] sr_calc;
  logic [mafi_pkg::OffsetBits:0] tail_sum;
  logic        tail_hit;
  logic [32:0] fsz;
  logic        fin_frame;

  logic [2:0]  dec_kind;
  logic [31:0] dec_off;
  logic [31:0] dec_size;
  logic [mafi_pkg::OffsetBits-1:0] dec_next;

  mafi_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor(rate_hz), .busy(div_busy), .quotient(div_q)
  );

  assign vid_ver = (cur.w0[20:19] == 2'd3) ? 2'd1 : ((cur.w0[20:19] == 2'd0) ? 2'd3 : 2'd2);
  assign lid_lay = (cur.w0[18:17] == 2'd3) ? 2'd1 : ((cur.w0[18:17] == 2'd2) ? 2'd2 : 2'd3);
  assign eff_ver = first_done ? mpeg_ver : vid_ver;
  assign eff_lay = first_done ? layer_num : lid_lay;
  assign br_calc = mafi_pkg::bitrate(eff_ver, eff_lay, cur.w0[15:12]);
  assign sr_calc = mafi_pkg::sample_rate(vid_ver, cur.w0[11:10]);
  assign tail_sum = {1'b0, cur_offset} + (mafi_pkg::OffsetBits+1)'(min_tail_bytes);
  assign tail_hit = !(tail_sum < (mafi_pkg::OffsetBits+1)'(file_length));
  assign fsz = {1'b0, div_q[31:0]} +
               (cur.w0[9] ? ((layer_num == 2'd1) ? 33'd4 : 33'd1) : 33'd0);

  // The frame fits in the stream and becomes a real record.
  assign fin_frame = (br != 9'd0) && (rate_hz != 16'd0) && (fsz != 33'd0) &&
                     (({1'b0, 32'(cur_offset)} + fsz) < {1'b0, file_length});

  // The next entry is taken only after the previous result has left.
  assign q_pop = (state == mafi_pkg::S_IDLE) && q_valid && !out_full;
  assign div_start = (state == mafi_pkg::S_MUL) || (state == mafi_pkg::S_TMUL);
  assign div_a = (state == mafi_pkg::S_MUL) ?
                 {32'd0, 32'(samples_frame) * 32'(br) * 32'd125} :
                 64'(tsamp) * 64'd1000000;

  // Record fields and next offset for a tag, a resync or a stopped scan.
  always_comb begin
    dec_kind = mafi_pkg::KIND_NONE;
    dec_off  = 32'(cur_offset);
    dec_size = 32'd0;
    dec_next = cur_offset;
    if (stopped == mafi_pkg::ST_RUN && !tail_hit) begin
      unique case (cur.cls) inside
        mafi_pkg::CL_SYNC: ;
        mafi_pkg::CL_ID3V1: begin
          dec_kind = mafi_pkg::KIND_ID3V1;
          dec_size = file_length - 32'(cur_offset);
        end
        mafi_pkg::CL_ID3V2: begin
          dec_kind = mafi_pkg::KIND_ID3V2;
          dec_size = {4'd0, cur.id3_size} + 32'd10;
          dec_next = cur_offset + mafi_pkg::OffsetBits'({4'd0, cur.id3_size})
                     + mafi_pkg::OffsetBits'(10);
        end
        mafi_pkg::CL_LYR, mafi_pkg::CL_XING, mafi_pkg::CL_VBRI: begin
          dec_kind = (cur.cls == mafi_pkg::CL_LYR) ? mafi_pkg::KIND_LYR :
                     ((cur.cls == mafi_pkg::CL_XING) ? mafi_pkg::KIND_XING :
                      mafi_pkg::KIND_VBRI);
          dec_next = cur_offset + mafi_pkg::OffsetBits'(32);
          dec_off  = 32'(cur_offset + mafi_pkg::OffsetBits'(32));
        end
        mafi_pkg::CL_APE: begin
          dec_kind = mafi_pkg::KIND_APE;
          dec_size = cur.w3 + 32'd8;
          dec_next = cur_offset + mafi_pkg::OffsetBits'(cur.w3 + 32'd8);
        end
        default: dec_next = cur_offset + mafi_pkg::OffsetBits'(1);
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      mafi_pkg::S_IDLE:   if (q_valid && !out_full) state_next = mafi_pkg::S_DECODE;
      mafi_pkg::S_DECODE: begin
        if (stopped == mafi_pkg::ST_RUN && !tail_hit && cur.cls == mafi_pkg::CL_SYNC)
          state_next = mafi_pkg::S_MUL;
        else state_next = mafi_pkg::S_OUT;
      end
      mafi_pkg::S_MUL:    state_next = mafi_pkg::S_DIV;
      mafi_pkg::S_DIV:    if (!div_busy) state_next = mafi_pkg::S_FINISH;
      mafi_pkg::S_FINISH: state_next = fin_frame ? mafi_pkg::S_TMUL : mafi_pkg::S_OUT;
      mafi_pkg::S_TMUL:   state_next = mafi_pkg::S_TDIV;
      mafi_pkg::S_TDIV:   if (!div_busy) state_next = mafi_pkg::S_OUT;
      mafi_pkg::S_OUT:    if (!out_full) state_next = mafi_pkg::S_IDLE;
      default:            state_next = mafi_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mafi_pkg::S_IDLE;
    else state <= state_next;
  end

  // Datapath and architectural state.
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
    if (rst) begin
      cur_offset <= '0; first_done <= 1'b0; stopped <= mafi_pkg::ST_RUN;
      mpeg_ver <= 2'd0; layer_num <= 2'd0; rate_hz <= 16'd0; samples_frame <= 11'd0;
      first_bitrate <= 9'd0; frame_cnt <= '0; size_sum <= 32'd0; size_max <= 16'd0;
      vbr_flag <= 1'b0; rate_sum <= 32'd0;
      out_full <= 1'b0;
    end else begin
      if (out_full && out_ready) out_full <= 1'b0;
      unique case (state)
        mafi_pkg::S_DECODE: begin
          record_kind <= dec_kind;
          record_offset <= dec_off;
          record_size <= dec_size;
          record_time <= 48'd0;
          next_offset <= 32'(dec_next);
          if (stopped == mafi_pkg::ST_RUN && tail_hit) stopped <= mafi_pkg::ST_STOP;
          else if (stopped == mafi_pkg::ST_RUN) begin
            cur_offset <= dec_next;
            if (cur.cls == mafi_pkg::CL_ID3V1) stopped <= mafi_pkg::ST_STOP;
            if (cur.cls == mafi_pkg::CL_SYNC) begin
              br <= br_calc;
              if (!first_done) begin
                mpeg_ver <= vid_ver;
                layer_num <= lid_lay;
                samples_frame <= mafi_pkg::samples_per_frame(vid_ver, lid_lay);
                if (sr_calc != 16'd0) rate_hz <= sr_calc;
                if (br_calc != 9'd0) begin
                  rate_sum <= rate_sum + 32'(br_calc);
                  if (frame_cnt == '0) first_bitrate <= br_calc;
                  else if (first_bitrate != br_calc) vbr_flag <= 1'b1;
                end
              end else begin
                rate_sum <= rate_sum + 32'(br_calc);
                if (first_bitrate != br_calc) vbr_flag <= 1'b1;
              end
            end
          end
        end
        mafi_pkg::S_FINISH: begin
          if (br != 9'd0 && rate_hz != 16'd0) begin
            record_size <= fsz[31:0];
            if (fin_frame) begin
              record_kind <= mafi_pkg::KIND_FRAME;
              next_offset <= 32'(cur_offset + mafi_pkg::OffsetBits'(fsz[31:0]));
              cur_offset <= cur_offset + mafi_pkg::OffsetBits'(fsz[31:0]);
              size_sum <= size_sum + fsz[31:0];
              tsamp <= 35'(frame_cnt) * 35'(samples_frame);
              frame_cnt <= frame_cnt + mafi_pkg::CountBits'(1);
              if (fsz > {17'd0, size_max})
                size_max <= (fsz > 33'd65535) ? 16'hFFFF : fsz[15:0];
              first_done <= 1'b1;
            end else if (fsz != 33'd0 && fsz <= 33'd1152) begin
              next_offset <= file_length;
              cur_offset <= mafi_pkg::OffsetBits'(file_length);
              stopped <= mafi_pkg::ST_END;
              first_done <= 1'b1;
            end else begin
              stopped <= mafi_pkg::ST_ERR;
            end
          end else begin
            next_offset <= 32'(cur_offset + mafi_pkg::OffsetBits'(1));
            cur_offset <= cur_offset + mafi_pkg::OffsetBits'(1);
            first_done <= 1'b1;
          end
        end
        mafi_pkg::S_TDIV: if (!div_busy) record_time <= div_q[47:0];
        mafi_pkg::S_OUT: if (!out_full) out_full <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid     = out_full;
  assign scan_status   = stopped;
  assign frames_seen   = 24'(frame_cnt);
  assign bytes_total   = size_sum;
  assign largest_frame = size_max;
  assign variable_rate = vbr_flag;
  assign bitrate_sum   = rate_sum;

endmodule

### rtl/mpeg_audio_frame_indexer_unit.sv
// Channel   Dir  Payload
// s_axis    in   tdata[127:0] four big-endian words at the current offset
// m_axis    out  tdata[255:0] one record with running totals
// apb       in   file_length (0x0), min_tail_bytes (0x4)
//
// Items classified by the front end enter a two-entry queue.
// An audio frame passes through two divisions by the sample rate in the back end.
// A sync word that yields no frame skips the time division; tags and resyncs skip the divider.
// One item is in the back end at a time, and it waits until the last result is taken.
// rst is synchronous; it clears the queue, scan state and totals.
// A stalled output holds the back end; the front keeps filling its queue.
module mpeg_audio_frame_indexer_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // word_at_offset, word_plus_four, word_plus_eight, word_plus_twelve
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // record_kind, record_offset, record_size, record_time, next_offset, scan_status,
  // frames_seen, bytes_total, largest_frame, variable_rate, bitrate_sum, 2 zero bits
  output logic [255:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [31:0] file_length;
  logic [9:0]  min_tail_bytes;
  logic        q_valid, q_pop;
  mafi_pkg::entry_t q_head;

  logic [2:0]  record_kind;
  logic [31:0] record_offset, record_size, next_offset, bytes_total, bitrate_sum;
  logic [47:0] record_time;
  logic [1:0]  scan_status;
  logic [23:0] frames_seen;
  logic [15:0] largest_frame;
  logic        variable_rate;

  // Configuration registers.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= 32'd0;
      min_tail_bytes <= 10'd128;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        mafi_pkg::ADDR_FILE_LENGTH[0]: file_length <= pwdata;
        default:                       min_tail_bytes <= pwdata[9:0];
      endcase
    end
  end

  always_comb begin
    prdata = (paddr[2] == mafi_pkg::ADDR_MIN_TAIL[0]) ? {22'd0, min_tail_bytes} : file_length;
  end

  mafi_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
  );

  mafi_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
    .file_length(file_length), .min_tail_bytes(min_tail_bytes),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .record_kind(record_kind), .record_offset(record_offset), .record_size(record_size),
    .record_time(record_time), .next_offset(next_offset), .scan_status(scan_status),
    .frames_seen(frames_seen), .bytes_total(bytes_total), .largest_frame(largest_frame),
    .variable_rate(variable_rate), .bitrate_sum(bitrate_sum)
  );

  assign m_axis_tdata = {2'd0, bitrate_sum, variable_rate, largest_frame, bytes_total,
                         frames_seen, scan_status, next_offset, record_time,
                         record_size, record_offset, record_kind};

endmodule

### rtl/mafi_checker.sv
// Port-level checks on the indexer.
module mafi_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [255:0] m_axis_tdata,
  input logic         pready
);

  // A held result does not change.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A resync record carries no size unless the scan stopped.
  a_kind0: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] == mafi_pkg::KIND_NONE &&
    m_axis_tdata[148:147] == mafi_pkg::ST_RUN |-> m_axis_tdata[66:35] == 32'd0)
    else $error("resync record with size");

  // Only frames carry a time.
  a_time: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] != mafi_pkg::KIND_FRAME |->
    m_axis_tdata[114:67] == 48'd0)
    else $error("time on a non-frame record");

  // After reset nothing is shown and input is taken.
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid && s_axis_tready && pready)
    else $error("bad state after reset");

endmodule

bind mpeg_audio_frame_indexer_unit mafi_checker u_mafi_checker (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .pready(pready)
);
